@@ sv/ncl_pkg.sv @@
// Shared types, widths and helpers for the near-plane triangle clipper.
`timescale 1ns / 1ps
package ncl_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// Near distance d = z + w, held one bit wider than a coordinate.
	localparam int DIST_W      = COORD_WIDTH + 1;
	// Divider remainder: the doubled remainder stays below twice the divisor.
	localparam int REM_W       = COORD_WIDTH + 2;
	// Raw quotient with one guard bit for rounding.
	localparam int Q_W         = FRAC_BITS + 1;
	localparam int DIV_STAGES  = FRAC_BITS + 1;
	localparam int LERP_STAGES = 3;
	localparam int LANE_LAT    = DIV_STAGES + LERP_STAGES;
	// Magnitude of a coordinate difference and its product with t.
	localparam int MAG_W       = COORD_WIDTH + 1;
	localparam int PROD_W      = MAG_W + Q_W;

	localparam int MAX_RESULTS = 6;
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vtx_t;

	typedef enum logic [1:0] {
		MODE_CULL = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_TWO  = 2'd2,
		MODE_ALL  = 2'd3
	} mode_t;

	// What one lane hands to the merging stage.
	typedef struct packed {
		vtx_t vin;
		vtx_t cut;
		vtx_t vout;
	} lane_res_t;

	// Control that travels alongside the lane data.
	typedef struct packed {
		logic  valid;
		mode_t mode;
	} tag_t;

	// Near-plane distance of a vertex, exact at DIST_W bits.
	function automatic logic signed [DIST_W-1:0] near_dist(vtx_t v);
		logic signed [DIST_W-1:0] zz;
		logic signed [DIST_W-1:0] ww;
		zz = DIST_W'($signed(v.z));
		ww = DIST_W'($signed(v.w));
		return zz + ww;
	endfunction

endpackage

@@ sv/ncl_divider.sv @@
// Pipelined restoring divider that forms the cut fraction for one lane.
`timescale 1ns / 1ps
module ncl_divider import ncl_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  vtx_t           vin,
	input  vtx_t           vout,
	output logic [Q_W-1:0] q,
	output vtx_t           vin_o,
	output vtx_t           vout_o
);

	logic signed [DIST_W-1:0] d_in;
	logic signed [DIST_W-1:0] d_out;
	logic signed [REM_W-1:0]  din_x;
	logic signed [REM_W-1:0]  dout_x;
	logic [REM_W-1:0]         rem0;
	logic [REM_W-1:0]         den0;

	logic [REM_W-1:0] rem_s  [DIV_STAGES];
	logic [REM_W-1:0] den_s  [DIV_STAGES];
	logic [Q_W-1:0]   q_s    [DIV_STAGES];
	vtx_t             vin_s  [DIV_STAGES];
	vtx_t             vout_s [DIV_STAGES];

	// Dividend is the inside distance, divisor the distance gap.
	always_comb begin
		d_in   = near_dist(vin);
		d_out  = near_dist(vout);
		din_x  = REM_W'(d_in);
		dout_x = REM_W'(d_out);
		rem0   = din_x;
		den0   = din_x - dout_x;
	end

	// One quotient bit per stage.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
		logic [REM_W-1:0] r_in;
		logic [REM_W-1:0] den_i;
		logic [REM_W-1:0] r2;
		logic [Q_W-1:0]   qi;
		vtx_t             a_i;
		vtx_t             b_i;

		if (g == 0) begin : g_first
			assign r_in  = rem0;
			assign den_i = den0;
			assign qi    = '0;
			assign a_i   = vin;
			assign b_i   = vout;
		end else begin : g_next
			assign r_in  = rem_s[g-1];
			assign den_i = den_s[g-1];
			assign qi    = q_s[g-1];
			assign a_i   = vin_s[g-1];
			assign b_i   = vout_s[g-1];
		end

		assign r2 = {r_in[REM_W-2:0], 1'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= den_i) begin
					rem_s[g] <= r2 - den_i;
					q_s[g]   <= {qi[Q_W-2:0], 1'b1};
				end else begin
					rem_s[g] <= r2;
					q_s[g]   <= {qi[Q_W-2:0], 1'b0};
				end
				den_s[g]  <= den_i;
				vin_s[g]  <= a_i;
				vout_s[g] <= b_i;
			end
		end
	end

	assign q      = q_s[DIV_STAGES-1];
	assign vin_o  = vin_s[DIV_STAGES-1];
	assign vout_o = vout_s[DIV_STAGES-1];

endmodule

@@ sv/ncl_lerp.sv @@
// Interpolation of the four coordinates at the cut fraction for one lane.
`timescale 1ns / 1ps
module ncl_lerp import ncl_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [Q_W-1:0] q,
	input  vtx_t           vin,
	input  vtx_t           vout,
	output lane_res_t      res
);

	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	coord_t ci [4];
	coord_t co [4];

	logic [Q_W:0]     q_rnd;
	logic [Q_W-1:0]   t_s1;
	logic [MAG_W-1:0] mag_s1  [4];
	logic             neg_s1  [4];
	logic             neg_s2  [4];
	coord_t           base_s1 [4];
	coord_t           base_s2 [4];
	logic [PROD_W-1:0] prod_s2 [4];
	coord_t           cut_s3  [4];
	vtx_t             vin_s1, vin_s2, vin_s3;
	vtx_t             vout_s1, vout_s2, vout_s3;

	assign ci[0] = vin.x;
	assign ci[1] = vin.y;
	assign ci[2] = vin.z;
	assign ci[3] = vin.w;
	assign co[0] = vout.x;
	assign co[1] = vout.y;
	assign co[2] = vout.z;
	assign co[3] = vout.w;

	// Round the quotient to nearest, ties upward.
	assign q_rnd = {1'b0, q} + (Q_W+1)'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= q_rnd[Q_W:1];
			vin_s1  <= vin;
			vout_s1 <= vout;
			vin_s2  <= vin_s1;
			vout_s2 <= vout_s1;
			vin_s3  <= vin_s2;
			vout_s3 <= vout_s2;
		end
	end

	// Per coordinate: difference, scaled magnitude, signed correction.
	for (genvar k = 0; k < 4; k++) begin : g_comp
		logic signed [MAG_W-1:0] delta;
		logic [PROD_W-1:0]       sum;
		logic [PROD_W-1:0]       shf;
		coord_t                  r_c;

		assign delta = MAG_W'(co[k]) - MAG_W'(ci[k]);
		assign sum   = prod_s2[k] + HALF;
		assign shf   = sum >> FRAC_BITS;
		assign r_c   = coord_t'(shf[COORD_WIDTH-1:0]);

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[k]  <= delta[MAG_W-1];
				mag_s1[k]  <= delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
				base_s1[k] <= ci[k];
				prod_s2[k] <= PROD_W'(mag_s1[k]) * PROD_W'(t_s1);
				neg_s2[k]  <= neg_s1[k];
				base_s2[k] <= base_s1[k];
				cut_s3[k]  <= neg_s2[k] ? base_s2[k] - r_c : base_s2[k] + r_c;
			end
		end
	end

	assign res.vin   = vin_s3;
	assign res.vout  = vout_s3;
	assign res.cut.x = cut_s3[0];
	assign res.cut.y = cut_s3[1];
	assign res.cut.z = cut_s3[2];
	assign res.cut.w = cut_s3[3];

endmodule

@@ sv/ncl_emit.sv @@
// Merging stage: holds both lanes' results and sends out one vertex per word.
`timescale 1ns / 1ps
module ncl_emit import ncl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tag_t       tag,
	input  lane_res_t  lane0,
	input  lane_res_t  lane1,
	input  logic       out_ready,
	output logic       adv,
	output logic       out_valid,
	output vtx_t       vtx,
	output logic [1:0] corner,
	output logic       last_vertex
);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	mode_t            mode_q;
	lane_res_t        l0_q;
	lane_res_t        l1_q;
	logic             load;

	assign out_valid = busy_q;
	assign adv       = !busy_q || (out_ready && last_vertex);
	assign load      = adv && tag.valid && (tag.mode != MODE_CULL);

	// Control: load a new triangle or step through its vertices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			mode_q <= MODE_CULL;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			mode_q <= tag.mode;
		end else if (busy_q && out_ready) begin
			if (last_vertex) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Held vertex sets.
	always_ff @(posedge clk) begin
		if (load) begin
			l0_q <= lane0;
			l1_q <= lane1;
		end
	end

	// Pick the vertex for the current word.
	always_comb begin
		vtx = l0_q.vin;
		case (idx_q)
			IDX_W'(0): vtx = l0_q.vin;
			IDX_W'(1): vtx = (mode_q == MODE_ALL) ? l1_q.vin : l0_q.cut;
			IDX_W'(2): vtx = (mode_q == MODE_ALL) ? l0_q.vout : l1_q.cut;
			IDX_W'(3): vtx = l0_q.vin;
			IDX_W'(4): vtx = l1_q.cut;
			IDX_W'(5): vtx = l1_q.vin;
			default:   vtx = l0_q.vin;
		endcase
	end

	// Corner within the output triangle and the final-word flag.
	always_comb begin
		case (idx_q) inside
			IDX_W'(0), IDX_W'(3): corner = 2'd0;
			IDX_W'(1), IDX_W'(4): corner = 2'd1;
			default:              corner = 2'd2;
		endcase
		last_vertex = (mode_q == MODE_TWO) ? (idx_q == IDX_W'(5)) : (idx_q == IDX_W'(2));
	end

	a_busy_mode: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (mode_q != MODE_CULL))
		else $error("emit busy with a culled triangle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && mode_q != MODE_TWO) |-> (idx_q <= IDX_W'(2)))
		else $error("vertex index beyond a single triangle");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !out_ready) |=> (busy_q && $stable(idx_q)))
		else $error("stalled word lost");

	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_ready && !last_vertex) |=> busy_q)
		else $error("triangle ended before its last vertex");

endmodule

@@ sv/near_plane_triangle_clipper_top.sv @@
// Top level: input register, two cut lanes, control tags and merging stage.
// The first vertex of a triangle passes the input register (at the accepting edge),
// 17 divider stages, 3 interpolation stages and the output register before it appears.
// A triangle leaves as three vertex words, or six when it splits into two; a culled
// triangle sends none. The pipeline moves on only while the output register is idle or
// sends its last word, so the receiver's back-pressure holds new triangles.
// Reset: arst_n clears all valid and control state asynchronously; data is not reset.
`timescale 1ns / 1ps
module near_plane_triangle_clipper_top import ncl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] a_x,
	input  logic [COORD_WIDTH-1:0] a_y,
	input  logic [COORD_WIDTH-1:0] a_z,
	input  logic [COORD_WIDTH-1:0] a_w,
	input  logic [COORD_WIDTH-1:0] b_x,
	input  logic [COORD_WIDTH-1:0] b_y,
	input  logic [COORD_WIDTH-1:0] b_z,
	input  logic [COORD_WIDTH-1:0] b_w,
	input  logic [COORD_WIDTH-1:0] c_x,
	input  logic [COORD_WIDTH-1:0] c_y,
	input  logic [COORD_WIDTH-1:0] c_z,
	input  logic [COORD_WIDTH-1:0] c_w,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_WIDTH-1:0] out_x,
	output logic [COORD_WIDTH-1:0] out_y,
	output logic [COORD_WIDTH-1:0] out_z,
	output logic [COORD_WIDTH-1:0] out_w,
	output logic [1:0]             corner,
	output logic                   last_vertex
);

	vtx_t       va, vb, vc;
	logic signed [DIST_W-1:0] dist_a, dist_b, dist_c;
	logic [2:0] in_front;
	vtx_t       l0_in, l0_out, l1_in, l1_out;
	mode_t      mode;
	logic       adv;

	vtx_t  l0_in_s1, l0_out_s1, l1_in_s1, l1_out_s1;
	logic  valid_s1;
	mode_t mode_s1;
	tag_t  tag_s1;
	tag_t  tag_pipe_q [LANE_LAT];

	logic [Q_W-1:0] q0, q1;
	vtx_t           d0_in, d0_out, d1_in, d1_out;
	lane_res_t      res0, res1;
	vtx_t           vtx;

	assign va = '{x: a_x, y: a_y, z: a_z, w: a_w};
	assign vb = '{x: b_x, y: b_y, z: b_z, w: b_w};
	assign vc = '{x: c_x, y: c_y, z: c_z, w: c_w};

	// Classify the vertices and route each edge to be cut to a lane.
	always_comb begin
		dist_a = near_dist(va);
		dist_b = near_dist(vb);
		dist_c = near_dist(vc);
		in_front[0] = !dist_a[DIST_W-1];
		in_front[1] = !dist_b[DIST_W-1];
		in_front[2] = !dist_c[DIST_W-1];
		mode   = MODE_ALL;
		l0_in  = va;
		l0_out = vc;
		l1_in  = vb;
		l1_out = vc;
		case (in_front)
			3'b111: mode = MODE_ALL;
			3'b000: mode = MODE_CULL;
			3'b001: begin
				mode = MODE_ONE;
				l0_in = va; l0_out = vb; l1_in = va; l1_out = vc;
			end
			3'b010: begin
				mode = MODE_ONE;
				l0_in = vb; l0_out = vc; l1_in = vb; l1_out = va;
			end
			3'b100: begin
				mode = MODE_ONE;
				l0_in = vc; l0_out = va; l1_in = vc; l1_out = vb;
			end
			3'b110: begin
				mode = MODE_TWO;
				l0_in = vb; l0_out = va; l1_in = vc; l1_out = va;
			end
			3'b101: begin
				mode = MODE_TWO;
				l0_in = vc; l0_out = vb; l1_in = va; l1_out = vb;
			end
			3'b011: begin
				mode = MODE_TWO;
				l0_in = va; l0_out = vc; l1_in = vb; l1_out = vc;
			end
			default: mode = MODE_CULL;
		endcase
	end

	assign in_ready = adv;
	assign tag_s1   = '{valid: valid_s1, mode: mode_s1};

	// Input register.
	always_ff @(posedge clk) begin
		if (adv) begin
			l0_in_s1  <= l0_in;
			l0_out_s1 <= l0_out;
			l1_in_s1  <= l1_in;
			l1_out_s1 <= l1_out;
			mode_s1   <= mode;
		end
	end

	// Valid and mode travel beside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < LANE_LAT; i++) begin
				tag_pipe_q[i] <= '{valid: 1'b0, mode: MODE_CULL};
			end
		end else if (adv) begin
			valid_s1      <= in_valid;
			tag_pipe_q[0] <= tag_s1;
			for (int i = 1; i < LANE_LAT; i++) begin
				tag_pipe_q[i] <= tag_pipe_q[i-1];
			end
		end
	end

	// Two cut lanes.
	ncl_divider u_div0 (
		.clk(clk), .en(adv), .vin(l0_in_s1), .vout(l0_out_s1),
		.q(q0), .vin_o(d0_in), .vout_o(d0_out)
	);
	ncl_divider u_div1 (
		.clk(clk), .en(adv), .vin(l1_in_s1), .vout(l1_out_s1),
		.q(q1), .vin_o(d1_in), .vout_o(d1_out)
	);
	ncl_lerp u_lerp0 (
		.clk(clk), .en(adv), .q(q0), .vin(d0_in), .vout(d0_out), .res(res0)
	);
	ncl_lerp u_lerp1 (
		.clk(clk), .en(adv), .q(q1), .vin(d1_in), .vout(d1_out), .res(res1)
	);

	// Merge and emit.
	ncl_emit u_emit (
		.clk(clk), .arst_n(arst_n), .tag(tag_pipe_q[LANE_LAT-1]),
		.lane0(res0), .lane1(res1), .out_ready(out_ready), .adv(adv),
		.out_valid(out_valid), .vtx(vtx), .corner(corner), .last_vertex(last_vertex)
	);

	assign out_x = vtx.x;
	assign out_y = vtx.y;
	assign out_z = vtx.z;
	assign out_w = vtx.w;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the near-plane triangle clipper.
`timescale 1ns / 1ps
module tb;
	import ncl_pkg::*;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_PASS, ROW_CULL} row_kind_t;

	typedef struct packed {
		vtx_t       v;
		logic [1:0] corner;
		logic       last;
	} clip_word_t;

	typedef struct {
		vtx_t      a;
		vtx_t      b;
		vtx_t      c;
		row_kind_t kind;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 480;

	logic   clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	coord_t a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, c_x, c_y, c_z, c_w;
	logic [COORD_WIDTH-1:0] out_x, out_y, out_z, out_w;
	logic [1:0] corner;
	logic       last_vertex;

	clip_word_t expected_words[$];
	row_kind_t  cur_kind;
	int         error_count, words_seen, tris_sent, cuts_seen;
	int         stall_cycles;
	logic       hold_go, no_idle;

	near_plane_triangle_clipper_top dut (.*);

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic vtx_t mk(coord_t x, coord_t y, coord_t z, coord_t w);
		return {x, y, z, w};
	endfunction

	function automatic clip_word_t mk_word(vtx_t v, logic [1:0] c, logic l);
		clip_word_t cw;
		cw.v = v;
		cw.corner = c;
		cw.last = l;
		return cw;
	endfunction

	// Appends one expected word at the tail of the queue.
	task automatic queue_word(clip_word_t cw);
		expected_words.insert(expected_words.size(), cw);
	endtask

	function automatic longint dist_of(vtx_t v);
		return longint'(v.z) + longint'(v.w);
	endfunction

	function automatic coord_t comp_of(vtx_t v, int k);
		logic [4*COORD_WIDTH-1:0] bits;
		bits = v;
		return bits[4*COORD_WIDTH-1-COORD_WIDTH*k -: COORD_WIDTH];
	endfunction

	// Point where the edge from the inside vertex k to the outside vertex o meets the plane.
	function automatic vtx_t cut_point(vtx_t k, vtx_t o);
		longint unsigned rem, den, q, t, mag, scaled;
		longint d_k, d_o, delta, p;
		logic [4*COORD_WIDTH-1:0] bits;
		d_k = dist_of(k);
		d_o = dist_of(o);
		den = d_k - d_o;
		rem = d_k;
		q = 0;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 1;
			end
		end
		t = (q + 1) >> 1;
		for (int j = 0; j < 4; j++) begin
			delta = longint'(comp_of(o, j)) - longint'(comp_of(k, j));
			mag = (delta >= 0) ? delta : -delta;
			scaled = (mag * t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			p = (delta >= 0) ? longint'(comp_of(k, j)) + longint'(scaled)
				: longint'(comp_of(k, j)) - longint'(scaled);
			bits[4*COORD_WIDTH-1-COORD_WIDTH*j -: COORD_WIDTH] = p[COORD_WIDTH-1:0];
		end
		return bits;
	endfunction

	// Clips one triangle and queues the vertex words it should produce.
	task automatic push_clipped(vtx_t va, vtx_t vb, vtx_t vc);
		vtx_t vs[3];
		vtx_t list[6];
		int n_in, pick, n;
		vs[0] = va; vs[1] = vb; vs[2] = vc;
		n_in = 0;
		for (int i = 0; i < 3; i++) if (dist_of(vs[i]) >= 0) n_in++;
		n = 0;
		if (n_in == 3) begin
			list[0] = va; list[1] = vb; list[2] = vc;
			n = 3;
		end else if (n_in == 1) begin
			pick = 0;
			for (int i = 2; i >= 0; i--) if (dist_of(vs[i]) >= 0) pick = i;
			list[0] = vs[pick];
			list[1] = cut_point(vs[pick], vs[(pick + 1) % 3]);
			list[2] = cut_point(vs[pick], vs[(pick + 2) % 3]);
			n = 3;
			cuts_seen++;
		end else if (n_in == 2) begin
			pick = 0;
			for (int i = 2; i >= 0; i--) if (dist_of(vs[i]) < 0) pick = i;
			list[0] = vs[(pick + 1) % 3];
			list[1] = cut_point(vs[(pick + 1) % 3], vs[pick]);
			list[2] = cut_point(vs[(pick + 2) % 3], vs[pick]);
			list[3] = list[0];
			list[4] = list[2];
			list[5] = vs[(pick + 2) % 3];
			n = 6;
			cuts_seen++;
		end
		for (int i = 0; i < n; i++)
			queue_word(mk_word(list[i], 2'(i % 3), (i == n - 1)));
	endtask

	task automatic report_mismatch(string what, logic [COORD_WIDTH-1:0] got,
			logic [COORD_WIDTH-1:0] want);
		$display("MISMATCH word %0d %s: got %h want %h", words_seen, what, got, want);
		error_count++;
	endtask

	// Input acceptance feeds the predictor; output words are checked in order.
	always @(posedge clk) begin
		clip_word_t ref_w;
		if (arst_n && in_valid && in_ready) begin
			tris_sent++;
			case (cur_kind)
				ROW_PASS: begin
					queue_word(mk_word({a_x, a_y, a_z, a_w}, 2'd0, 1'b0));
					queue_word(mk_word({b_x, b_y, b_z, b_w}, 2'd1, 1'b0));
					queue_word(mk_word({c_x, c_y, c_z, c_w}, 2'd2, 1'b1));
				end
				ROW_CULL: ;
				default: push_clipped({a_x, a_y, a_z, a_w}, {b_x, b_y, b_z, b_w},
					{c_x, c_y, c_z, c_w});
			endcase
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", out_x, '0);
			end else begin
				ref_w = expected_words.pop_front();
				if (out_x !== ref_w.v.x) report_mismatch("x", out_x, ref_w.v.x);
				if (out_y !== ref_w.v.y) report_mismatch("y", out_y, ref_w.v.y);
				if (out_z !== ref_w.v.z) report_mismatch("z", out_z, ref_w.v.z);
				if (out_w !== ref_w.v.w) report_mismatch("w", out_w, ref_w.v.w);
				if (corner !== ref_w.corner)
					report_mismatch("corner", COORD_WIDTH'(corner),
						COORD_WIDTH'(ref_w.corner));
				if (last_vertex !== ref_w.last)
					report_mismatch("last_vertex", COORD_WIDTH'(last_vertex),
						COORD_WIDTH'(ref_w.last));
			end
			words_seen++;
		end
	end

	// Watchdog on cycles where neither side moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d words pending", expected_words.size());
			$display("tb failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = no_idle || ($urandom_range(99) >= 13);
		end
	end

	// Builds one random vertex on the requested side of the plane.
	function automatic vtx_t rand_vertex(bit want_inside, bit full_range);
		vtx_t v;
		int sel;
		do begin
			sel = $urandom_range(9);
			if (full_range || sel == 0)
				v = mk($urandom, $urandom, $urandom, $urandom);
			else
				v = mk($signed($urandom_range(2**22)) - 2**21,
					$signed($urandom_range(2**22)) - 2**21,
					$signed($urandom_range(2**22)) - 2**21,
					$signed($urandom_range(2**22)) - 2**21);
			// Now and then land exactly on the plane.
			if (sel == 1 && v.w != 32'sh80000000) v.z = -v.w;
		end while ((dist_of(v) >= 0) != want_inside);
		return v;
	endfunction

	task automatic send_tri(vtx_t va, vtx_t vb, vtx_t vc, row_kind_t kind);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 13) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		{a_x, a_y, a_z, a_w} = va;
		{b_x, b_y, b_z, b_w} = vb;
		{c_x, c_y, c_z, c_w} = vc;
		cur_kind = kind;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_tri;
		int n_in;
		bit full;
		bit ins[3];
		n_in = $urandom_range(3);
		full = ($urandom_range(3) == 0);
		ins = '{n_in >= 1, n_in >= 2, n_in >= 3};
		ins.shuffle();
		send_tri(rand_vertex(ins[0], full), rand_vertex(ins[1], full),
			rand_vertex(ins[2], full), ROW_PREDICT);
	endtask

	localparam coord_t CMAX = 32'sh7fffffff;
	localparam coord_t CMIN = 32'sh80000000;
	localparam coord_t ONE  = 32'sh00010000;

	stim_row_t directed[$];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		hold_go = 1'b0;
		no_idle = 1'b0;
		cur_kind = ROW_PREDICT;
		{a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, c_x, c_y, c_z, c_w} = '0;
		error_count = 0; words_seen = 0; tris_sent = 0; cuts_seen = 0; stall_cycles = 0;
		// Directed rows: plain cases, extremes, each clipping shape, on-plane vertices.
		directed = '{
			'{mk(0, 0, 0, ONE), mk(ONE, 0, 0, ONE), mk(0, ONE, 0, ONE), ROW_PASS},
			'{mk(0, 0, -2*ONE, ONE), mk(ONE, 0, -2*ONE, ONE), mk(0, ONE, -3*ONE, ONE),
				ROW_CULL},
			'{mk(CMAX, CMIN, CMAX, CMAX), mk(CMIN, CMAX, 0, 0), mk(-1, 1, 1, -1), ROW_PASS},
			'{mk(CMAX, CMAX, CMIN, CMIN), mk(CMIN, CMIN, CMIN, 0), mk(0, -1, -1, 0), ROW_CULL},
			'{mk(0, 0, 0, 0), mk(0, 0, 0, 0), mk(0, 0, 0, 0), ROW_PASS},
			'{mk(ONE, 2*ONE, ONE, ONE), mk(-ONE, 0, -3*ONE, ONE), mk(0, -ONE, -2*ONE, 0),
				ROW_PREDICT},
			'{mk(-ONE, 0, -3*ONE, ONE), mk(ONE, 2*ONE, ONE, ONE), mk(0, -ONE, -2*ONE, 0),
				ROW_PREDICT},
			'{mk(-ONE, 0, -3*ONE, ONE), mk(0, -ONE, -2*ONE, 0), mk(ONE, 2*ONE, ONE, ONE),
				ROW_PREDICT},
			'{mk(5, 7, -9*ONE, ONE), mk(ONE, 3*ONE, 0, ONE), mk(-ONE, ONE, 2*ONE, ONE),
				ROW_PREDICT},
			'{mk(ONE, 3*ONE, 0, ONE), mk(5, 7, -9*ONE, ONE), mk(-ONE, ONE, 2*ONE, ONE),
				ROW_PREDICT},
			'{mk(ONE, 3*ONE, 0, ONE), mk(-ONE, ONE, 2*ONE, ONE), mk(5, 7, -9*ONE, ONE),
				ROW_PREDICT},
			'{mk(3, 4, -ONE, ONE), mk(ONE, ONE, -2*ONE, 0), mk(0, ONE, -5*ONE, ONE),
				ROW_PREDICT},
			'{mk(CMAX, CMAX, CMAX, CMAX), mk(CMIN, CMIN, CMIN, CMIN), mk(CMIN, CMAX, CMIN, -1),
				ROW_PREDICT},
			'{mk(CMIN, CMAX, CMAX, 0), mk(CMAX, CMIN, CMIN, CMIN), mk(0, CMIN, 0, CMAX),
				ROW_PREDICT},
			'{mk(1, -1, 1, 0), mk(-7, 9, -1, 0), mk(CMAX, CMIN, CMIN, CMAX), ROW_PREDICT}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_tri(directed[i].a, directed[i].b, directed[i].c, directed[i].kind);

		// Long receiver hold-off while the sender keeps pushing, so the pipe backs up.
		no_idle = 1'b1;
		hold_go = 1'b1;
		repeat (40) send_random_tri();
		// Stretch with no idling on either side.
		repeat (80) send_random_tri();
		no_idle = 1'b0;
		repeat (RANDOM_ITEMS - 120) send_random_tri();
		@(negedge clk);
		in_valid = 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d triangles (%0d needing a cut) and %0d vertex words,",
			tris_sent, cuts_seen, words_seen);
		$display("including full-range coordinates, on-plane vertices and a long output stall.");
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
